// ----- rtl/core/tdpt_pkg.sv -----
package tdpt_pkg;

    // width of the number under test, low bits of the input beat
    localparam int NUMBER_WIDTH = 32;
    // fixed width of the input field
    localparam int IN_W  = 32;
    // odd trial divisor, holds values just past the square root
    localparam int DIV_W = NUMBER_WIDTH / 2 + 1;
    // square of the divisor
    localparam int SQ_W  = 2 * DIV_W;
    // bit counter of the restoring division
    localparam int CNT_W = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // latch the number from the input beat
        logic init_div;   // divisor = 3, square = 9
        logic start_div;  // clear remainder, load dividend shifter
        logic step_div;   // one restoring division step
        logic next_div;   // divisor += 2, square updated
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic below_two;  // number is zero or one
        logic is_two;     // number equals two
        logic is_even;    // low bit clear
        logic in_bound;   // divisor squared <= number
        logic div_last;   // current step is the final division step
        logic rem_zero;   // registered remainder is zero
    } t_dp_status;

endpackage

// ----- rtl/core/trial_division_prime_test_core.sv -----
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+-----------------------------
// input    | i_in_valid  | o_in_stall  | i_number_value [31:0]
// output   | o_out_valid | i_out_stall | o_prime_flag
//
// an odd number n >= 3 is divided by the odd divisors 3, 5, 7 and on until one divides it
// or the divisor squared exceeds n, so up to about sqrt(n)/2 divisors are tried; the
// bit-serial remainder unit works out each remainder one bit per cycle.
// zero, one, two and even numbers finish without any division.
// reset is synchronous, active low, and clears the controller and output valid.
// a new beat is taken once the previous result sits in the output register;
// a stalled output holds its beat and the core waits to post the next one.
module trial_division_prime_test_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [tdpt_pkg::IN_W-1:0] i_number_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_prime_flag
);
    import tdpt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer and output register
    tdpt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_prime_flag (o_prime_flag),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    // number, divisor and remainder unit
    tdpt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_number_value (i_number_value),
        .i_cmd          (w_cmd),
        .o_status       (w_status)
    );

endmodule

// ----- rtl/core/tdpt_datapath.sv -----
module tdpt_datapath (
    input  logic                         i_clk,
    input  logic [tdpt_pkg::IN_W-1:0]    i_number_value,
    input  tdpt_pkg::t_dp_cmd            i_cmd,
    output tdpt_pkg::t_dp_status         o_status
);
    import tdpt_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUMBER_WIDTH - 1);
    localparam logic [DIV_W-1:0] DIV_INIT = DIV_W'(3);
    localparam logic [DIV_W-1:0] DIV_INC  = DIV_W'(2);
    localparam logic [SQ_W-1:0]  SQ_INIT  = SQ_W'(9);
    localparam logic [SQ_W-1:0]  SQ_INC   = SQ_W'(4);

    logic [NUMBER_WIDTH-1:0]      r_number;
    logic [DIV_W-1:0]             r_divisor;
    logic [SQ_W-1:0]              r_square;
    logic [NUMBER_WIDTH-1:0]      r_dividend;
    logic [DIV_W-1:0]             r_rem;
    logic [CNT_W-1:0]             r_cnt;

    logic [NUMBER_WIDTH+IN_W-1:0] w_in_wide;
    logic [DIV_W:0]               w_trial;
    logic [DIV_W:0]               w_diff;
    logic                         w_fits;
    logic [DIV_W-1:0]             n_rem;

    // keep only the low number bits of the input beat
    assign w_in_wide = {{NUMBER_WIDTH{1'b0}}, i_number_value};

    // one restoring division step: shift in next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_dividend[NUMBER_WIDTH-1]};
        w_diff  = w_trial - {1'b0, r_divisor};
        w_fits  = (w_trial >= {1'b0, r_divisor});
        n_rem   = w_fits ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
    end

    // number, divisor and square registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_number <= w_in_wide[NUMBER_WIDTH-1:0];
        end
        if (i_cmd.init_div) begin
            r_divisor <= DIV_INIT;
            r_square  <= SQ_INIT;
        end else if (i_cmd.next_div) begin
            r_divisor <= r_divisor + DIV_INC;
            r_square  <= r_square + {{(SQ_W-DIV_W-2){1'b0}}, r_divisor, 2'b00} + SQ_INC;
        end
    end

    // division shifter, remainder and bit counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_dividend <= r_number;
            r_rem      <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.step_div) begin
            r_dividend <= {r_dividend[NUMBER_WIDTH-2:0], 1'b0};
            r_rem      <= n_rem;
            r_cnt      <= r_cnt + CNT_W'(1);
        end
    end

    // status back to the controller
    always_comb begin
        o_status.below_two = (r_number[NUMBER_WIDTH-1:1] == '0);
        o_status.is_two    = (r_number == NUMBER_WIDTH'(2));
        o_status.is_even   = ~r_number[0];
        o_status.in_bound  = (r_square <= {{(SQ_W-NUMBER_WIDTH){1'b0}}, r_number});
        o_status.div_last  = (r_cnt == CNT_LAST);
        o_status.rem_zero  = (r_rem == '0);
    end

endmodule

// ----- rtl/core/tdpt_ctrl.sv -----
module tdpt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_prime_flag,
    input  tdpt_pkg::t_dp_status  i_status,
    output tdpt_pkg::t_dp_cmd     o_cmd
);
    import tdpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_BOUND,
        S_DIVIDE,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   r_prime;
    logic   r_result;
    logic   n_result;
    logic   w_in_beat;
    logic   w_out_free;

    assign w_in_beat  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state, result and datapath commands
    always_comb begin
        n_state = r_state;
        n_result = r_result;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                if (i_status.below_two) begin
                    n_result = 1'b0;
                    n_state = S_FINISH;
                end else if (i_status.is_two) begin
                    n_result = 1'b1;
                    n_state = S_FINISH;
                end else if (i_status.is_even) begin
                    n_result = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.init_div = 1'b1;
                    n_state = S_BOUND;
                end
            end
            S_BOUND: begin
                if (i_status.in_bound) begin
                    o_cmd.start_div = 1'b1;
                    n_state = S_DIVIDE;
                end else begin
                    n_result = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_DIVIDE: begin
                o_cmd.step_div = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.rem_zero) begin
                    n_result = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state = S_BOUND;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_result    <= 1'b0;
            r_prime     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
            if (r_state == S_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
                r_prime     <= r_result;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_prime_flag = r_prime;

endmodule

// ----- rtl/core/tdpt_checker.sv -----
module tdpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_prime_flag
);

    // reset leaves the core ready and with no result posted
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("core not idle after reset");

    // an accepted beat keeps the input stalled while it is worked on
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // a newly posted result frees the input side
    a_post_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result posted while still busy");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_prime_flag)))
        else $error("stalled result beat changed");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_prime_flag (o_prime_flag)
);

// ----- sim/trial_division_prime_test_core_tb.sv -----
module trial_division_prime_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdpt_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int HOLD_CYCLES     = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 400000;
    localparam int RANDOM_NUMBERS  = 100;

    // expected prime flags, one per accepted number
    class prime_scoreboard;
        bit          expected_flags[$];
        int unsigned errors;
        int unsigned numbers_checked;
        int unsigned primes_seen;

        function new();
            errors          = 0;
            numbers_checked = 0;
            primes_seen     = 0;
        endfunction

        // trial division on the low NUMBER_WIDTH bits
        function bit predict_prime(logic [IN_W-1:0] raw);
            longint unsigned mask;
            longint unsigned n;
            longint unsigned d;
            mask = ((64'd1 << (NUMBER_WIDTH - 1)) << 1) - 64'd1;
            n    = longint'(raw) & mask;
            if (n < 2) return 1'b0;
            if (n == 2) return 1'b1;
            if (n[0] == 1'b0) return 1'b0;
            d = 3;
            while (d <= n / d) begin
                if (n % d == 0) return 1'b0;
                d += 2;
            end
            return 1'b1;
        endfunction

        function void note_number(logic [IN_W-1:0] value);
            expected_flags.push_back(predict_prime(value));
        endfunction

        function void check_flag(logic flag);
            bit want;
            if (expected_flags.size() == 0) begin
                $error("prime_flag beat with no number pending: actual %0b", flag);
                errors++;
                return;
            end
            want = expected_flags.pop_front();
            numbers_checked++;
            if (want) primes_seen++;
            if (flag !== want) begin
                $error("prime_flag mismatch: expected %0b actual %0b", want, flag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic [IN_W-1:0] number_value = '0;
    logic            out_stall = 1'b0;
    logic            o_in_stall;
    logic            o_out_valid;
    logic            o_prime_flag;

    prime_scoreboard scoreboard = new();
    bit              hold_request = 1'b0;
    int unsigned     idle_cycles = 0;

    trial_division_prime_test_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_number_value (number_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_prime_flag   (o_prime_flag)
    );

    always #1 i_clk = ~i_clk;

    // back to back almost half the time, as often short gaps, a few long ones
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 100);
    endfunction

    // keep trial counts low: small and medium values, full-width evens and
    // full-width multiples of a small odd factor
    function automatic logic [IN_W-1:0] random_number();
        int unsigned r;
        int unsigned f;
        logic [IN_W-1:0] value;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            value = $urandom_range(0, 65535);
        end else if (r < 70) begin
            value = $urandom_range(0, 1048575);
        end else if (r < 85) begin
            value = $urandom();
            value[0] = 1'b0;
        end else begin
            f = 2 * $urandom_range(1, 49) + 1;
            value = f * $urandom_range(1, 32'hFFFF_FFFF / f);
        end
        return value;
    endfunction

    // offer one beat, hold it until taken
    task automatic send_number(input logic [IN_W-1:0] value, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        number_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        scoreboard.note_number(value);
    endtask

    task automatic wait_drained();
        while (scoreboard.pending() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall pattern, plus one long hold on request
    initial begin
        int r;
        int len;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    out_stall <= 1'b0;
                    len = $urandom_range(1, 40);
                end else if (r < 90) begin
                    out_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    len = $urandom_range(20, 80);
                end
                repeat (len) @(posedge i_clk);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            scoreboard.check_flag(o_prime_flag);
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [IN_W-1:0] directed[$];
        int gap;
        logic [IN_W-1:0] value;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner values: zero, one, two, evens, small primes, prime squares
        // on the bound, full-width patterns, one large prime and one large square
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd8,
                     32'd9, 32'd15, 32'd25, 32'd49, 32'd97, 32'd121,
                     32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
                     32'hAAAA_AAAB, 32'h5555_5555, 32'd65537,
                     32'd16777213, 32'd16752649};
        foreach (directed[k])
            send_number(directed[k], sender_gap());

        // sender pauses until every result is back
        in_valid <= 1'b0;
        wait_drained();

        for (int k = 0; k < RANDOM_NUMBERS; k++) begin
            // long receiver hold while the sender keeps pushing small numbers
            if (k == 30) hold_request = 1'b1;
            if (k >= 30 && k < 38) begin
                value = $urandom_range(0, 255);
                gap   = 0;
            end else begin
                value = random_number();
                gap   = (k >= 60 && k < 76) ? 0 : sender_gap();
            end
            send_number(value, gap);
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d numbers (%0d prime): directed corners plus random",
                 scoreboard.numbers_checked, scoreboard.primes_seen);
        $display("small, medium and full-width values under random idling and stalls");
        if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (scoreboard.pending() != 0)
                $error("%0d prime_flag results never arrived", scoreboard.pending());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_datapath.sv
rtl/core/tdpt_ctrl.sv
rtl/core/trial_division_prime_test_core.sv
rtl/core/tdpt_checker.sv
sim/trial_division_prime_test_core_tb.sv
